### design/bsl_pkg.sv
// Shared types and constants for the band sweep lock controller.
package bsl_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned US_PER_MS   = 1000;

   localparam logic [8:0]  CHANNEL_COUNT_RST    = 9'd16;
   localparam logic [15:0] DWELL_MS_RST         = 16'd100;
   localparam logic [5:0]  LOCK_MIN_PULSES_RST  = 6'd16;
   localparam logic [15:0] QUIET_MS_RST         = 16'd500;
   localparam logic [15:0] DUMP_INTERVAL_MS_RST = 16'd400;
   localparam logic [5:0]  DUMP_MIN_PULSES_RST  = 6'd4;
   localparam logic [15:0] SHORT_PULSE_US_RST   = 16'd400;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNEL_COUNT    = 3'd0,
      CSR_DWELL_MS         = 3'd1,
      CSR_LOCK_MIN_PULSES  = 3'd2,
      CSR_QUIET_MS         = 3'd3,
      CSR_DUMP_INTERVAL_MS = 3'd4,
      CSR_DUMP_MIN_PULSES  = 3'd5,
      CSR_SHORT_PULSE_US   = 3'd6
   } bsl_csr_type;

   typedef enum logic [1:0] {
      OP_EDGE  = 2'd0,
      OP_POLL  = 2'd1,
      OP_START = 2'd2,
      OP_STOP  = 2'd3
   } bsl_op_type;

   typedef enum logic [1:0] {
      KIND_TUNE   = 2'd0,
      KIND_LOCK   = 2'd1,
      KIND_RECORD = 2'd2
   } bsl_kind_type;

   typedef struct packed {
      logic         latch;
      logic         edge_store;
      logic         capture_off;
      logic         start;
      logic         lock;
      logic         hop;
      logic         dump_begin;
      logic         resume;
      logic         emit;
      bsl_kind_type emit_kind;
      logic         emit_last;
   } bsl_cmd_type;

   typedef struct packed {
      bsl_op_type op;
      logic       locked;
      logic       lock_hit;
      logic       dwell_hit;
      logic       dump_hit;
      logic       quiet_hit;
      logic       fill_nz;
      logic       dump_final;
      logic       slot_free;
   } bsl_stat_type;

endpackage

### design/bsl_req_if.sv
// Request channel: event word with microsecond and millisecond timestamps.
interface bsl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] now_us;
   logic [31:0] now_ms;

   modport source (output valid, output operation, output now_us, output now_ms,
                   input ready);
   modport sink (input valid, input operation, input now_us, input now_ms,
                 output ready);
endinterface

### design/bsl_rsp_if.sv
// Response channel: tune, lock and pulse record words.
interface bsl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  channel;
   logic [31:0] pulse_width_us;
   logic        pulse_level;
   logic        pulse_short;
   logic [5:0]  pulse_total;
   logic        last;

   modport source (output valid, output kind, output channel, output pulse_width_us,
                   output pulse_level, output pulse_short, output pulse_total,
                   output last, input ready);
   modport sink (input valid, input kind, input channel, input pulse_width_us,
                 input pulse_level, input pulse_short, input pulse_total,
                 input last, output ready);
endinterface

### design/bsl_ctrl.sv
// Sequencer that decodes each request word and steps the datapath through it.
module bsl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bsl_pkg::bsl_stat_type stat,
   output bsl_pkg::bsl_cmd_type  cmd
);
   import bsl_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DUMP,
      ST_EMIT_TUNE,
      ST_EMIT_LOCK
   } state_type;

   state_type state_ff, state_in;
   logic      quiet_pend_ff, quiet_pend_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.emit_kind = KIND_TUNE;
      state_in      = state_ff;
      quiet_pend_in = quiet_pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (stat.op)
               OP_EDGE: begin
                  cmd.edge_store = 1'b1;
                  state_in       = ST_IDLE;
               end
               OP_STOP: begin
                  cmd.capture_off = 1'b1;
                  state_in        = ST_IDLE;
               end
               OP_START: begin
                  cmd.start = 1'b1;
                  state_in  = ST_EMIT_TUNE;
               end
               OP_POLL: begin
                  if (!stat.locked) begin
                     if (stat.lock_hit) begin
                        cmd.lock = 1'b1;
                        state_in = ST_EMIT_LOCK;
                     end else if (stat.dwell_hit) begin
                        cmd.hop  = 1'b1;
                        state_in = ST_EMIT_TUNE;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end else begin
                     quiet_pend_in  = stat.quiet_hit;
                     cmd.resume     = stat.quiet_hit;
                     cmd.dump_begin = stat.dump_hit;
                     if (stat.dump_hit && stat.fill_nz) begin
                        state_in = ST_DUMP;
                     end else if (stat.quiet_hit) begin
                        state_in = ST_EMIT_TUNE;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DUMP: begin
            if (stat.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_RECORD;
               cmd.emit_last = stat.dump_final && !quiet_pend_ff;
               if (stat.dump_final) begin
                  state_in = quiet_pend_ff ? ST_EMIT_TUNE : ST_IDLE;
               end
            end
         end
         ST_EMIT_TUNE: begin
            if (stat.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_TUNE;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_EMIT_LOCK: begin
            if (stat.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_LOCK;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         quiet_pend_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         quiet_pend_ff <= quiet_pend_in;
      end
   end

endmodule

### design/bsl_datapath.sv
// Registers, pulse store, timing compares and response register of the scanner.
module bsl_datapath #(
   parameter int unsigned MAX_PULSES = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [1:0]                           req_operation,
   input  logic [31:0]                          req_now_us,
   input  logic [31:0]                          req_now_ms,
   input  logic                                 csr_we,
   input  logic [bsl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bsl_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  bsl_pkg::bsl_cmd_type                 cmd,
   output bsl_pkg::bsl_stat_type                stat,
   bsl_rsp_if.source                            rsp_if
);
   import bsl_pkg::*;

   localparam int unsigned FW = $clog2(MAX_PULSES + 1);
   localparam int unsigned AW = $clog2(MAX_PULSES);

   bsl_op_type  op_ff;
   logic [31:0] now_us_ff, now_ms_ff;

   logic [8:0]  chan_count_ff;
   logic [15:0] dwell_ms_ff, quiet_ms_ff, dump_ivl_ff, short_us_ff;
   logic [5:0]  lock_min_ff, dump_min_ff;
   logic [25:0] quiet_us_ff;

   logic          locked_ff, capture_on_ff;
   logic [7:0]    sweep_ch_ff, lock_ch_ff;
   logic [31:0]   entered_ms_ff, dumped_ms_ff, prev_edge_ff;
   logic [FW-1:0] fill_ff, total_ff, idx_ff, idx_in;
   logic [31:0]   rd_data_ff;
   logic [31:0]   store_mem [MAX_PULSES];

   logic          store_en, tune_go, slot_free;
   logic [7:0]    tune_ch;
   logic [31:0]   delta_us;
   logic [AW-1:0] rd_addr;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [7:0]  rsp_channel_ff;
   logic [31:0] rsp_width_ff;
   logic        rsp_level_ff, rsp_short_ff, rsp_last_ff;
   logic [5:0]  rsp_total_ff;

   function automatic logic [7:0] next_ch(input logic [7:0] c, input logic [8:0] cnt);
      logic [8:0] n;
      n = {1'b0, c} + 9'd1;
      if (n >= cnt || n > 9'd255) begin
         next_ch = 8'd0;
      end else begin
         next_ch = n[7:0];
      end
   endfunction

   assign delta_us  = now_us_ff - prev_edge_ff;
   assign store_en  = cmd.edge_store && capture_on_ff && (fill_ff < FW'(MAX_PULSES));
   assign tune_go   = cmd.start || cmd.hop || cmd.resume;
   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      if (cmd.hop) begin
         tune_ch = next_ch(sweep_ch_ff, chan_count_ff);
      end else if (cmd.resume) begin
         tune_ch = next_ch(lock_ch_ff, chan_count_ff);
      end else begin
         tune_ch = 8'd0;
      end
   end

   always_comb begin
      if (cmd.dump_begin) begin
         idx_in = '0;
      end else if (cmd.emit && cmd.emit_kind == KIND_RECORD) begin
         idx_in = idx_ff + FW'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   assign rd_addr = (idx_in < FW'(MAX_PULSES)) ? idx_in[AW-1:0] : '0;

   always_comb begin
      stat            = '0;
      stat.op         = op_ff;
      stat.locked     = locked_ff;
      stat.lock_hit   = 7'(fill_ff) >= 7'(lock_min_ff);
      stat.dwell_hit  = (now_ms_ff - entered_ms_ff) >= 32'(dwell_ms_ff);
      stat.dump_hit   = ((now_ms_ff - dumped_ms_ff) >= 32'(dump_ivl_ff))
                        && (7'(fill_ff) >= 7'(dump_min_ff));
      stat.quiet_hit  = delta_us > 32'(quiet_us_ff);
      stat.fill_nz    = fill_ff != '0;
      stat.dump_final = idx_ff == (total_ff - FW'(1));
      stat.slot_free  = slot_free;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff     <= bsl_op_type'(req_operation);
         now_us_ff <= req_now_us;
         now_ms_ff <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff <= CHANNEL_COUNT_RST;
         dwell_ms_ff   <= DWELL_MS_RST;
         lock_min_ff   <= LOCK_MIN_PULSES_RST;
         quiet_ms_ff   <= QUIET_MS_RST;
         dump_ivl_ff   <= DUMP_INTERVAL_MS_RST;
         dump_min_ff   <= DUMP_MIN_PULSES_RST;
         short_us_ff   <= SHORT_PULSE_US_RST;
      end else if (csr_we) begin
         case (bsl_csr_type'(csr_index))
            CSR_CHANNEL_COUNT:    chan_count_ff <= csr_wdata[8:0];
            CSR_DWELL_MS:         dwell_ms_ff   <= csr_wdata;
            CSR_LOCK_MIN_PULSES:  lock_min_ff   <= csr_wdata[5:0];
            CSR_QUIET_MS:         quiet_ms_ff   <= csr_wdata;
            CSR_DUMP_INTERVAL_MS: dump_ivl_ff   <= csr_wdata;
            CSR_DUMP_MIN_PULSES:  dump_min_ff   <= csr_wdata[5:0];
            CSR_SHORT_PULSE_US:   short_us_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      quiet_us_ff <= 26'(quiet_ms_ff) * 26'(US_PER_MS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff     <= 1'b0;
         capture_on_ff <= 1'b0;
         sweep_ch_ff   <= 8'd0;
         lock_ch_ff    <= 8'd0;
         entered_ms_ff <= 32'd0;
         dumped_ms_ff  <= 32'd0;
         prev_edge_ff  <= 32'd0;
         fill_ff       <= '0;
         total_ff      <= '0;
         idx_ff        <= '0;
      end else begin
         idx_ff <= idx_in;
         if (cmd.edge_store) begin
            prev_edge_ff <= now_us_ff;
            if (store_en) begin
               fill_ff <= fill_ff + FW'(1);
            end
         end
         if (cmd.capture_off) begin
            capture_on_ff <= 1'b0;
         end
         if (cmd.start) begin
            capture_on_ff <= 1'b1;
            locked_ff     <= 1'b0;
         end
         if (cmd.lock) begin
            locked_ff    <= 1'b1;
            lock_ch_ff   <= sweep_ch_ff;
            dumped_ms_ff <= 32'd0;
         end
         if (cmd.dump_begin) begin
            dumped_ms_ff <= now_ms_ff;
            total_ff     <= fill_ff;
            fill_ff      <= '0;
         end
         if (cmd.resume) begin
            locked_ff <= 1'b0;
         end
         if (tune_go) begin
            sweep_ch_ff   <= tune_ch;
            fill_ff       <= '0;
            prev_edge_ff  <= now_us_ff;
            entered_ms_ff <= now_ms_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         store_mem[fill_ff[AW-1:0]] <= delta_us;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff  <= cmd.emit_kind;
         rsp_last_ff  <= cmd.emit_last;
         rsp_width_ff <= 32'd0;
         rsp_level_ff <= 1'b0;
         rsp_short_ff <= 1'b0;
         rsp_total_ff <= 6'd0;
         case (cmd.emit_kind)
            KIND_TUNE: rsp_channel_ff <= sweep_ch_ff;
            KIND_LOCK: rsp_channel_ff <= lock_ch_ff;
            KIND_RECORD: begin
               rsp_channel_ff <= lock_ch_ff;
               rsp_width_ff   <= rd_data_ff;
               rsp_level_ff   <= idx_ff[0];
               rsp_short_ff   <= rd_data_ff < 32'(short_us_ff);
               rsp_total_ff   <= 6'(total_ff);
            end
            default: rsp_channel_ff <= sweep_ch_ff;
         endcase
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.kind           = rsp_kind_ff;
   assign rsp_if.channel        = rsp_channel_ff;
   assign rsp_if.pulse_width_us = rsp_width_ff;
   assign rsp_if.pulse_level    = rsp_level_ff;
   assign rsp_if.pulse_short    = rsp_short_ff;
   assign rsp_if.pulse_total    = rsp_total_ff;
   assign rsp_if.last           = rsp_last_ff;

endmodule

### design/band_sweep_lock_controller_unit.sv
// Top level of the band sweep lock controller: sequencer plus datapath.
// Edge and stop words finish in the execute state; the next word is taken back in idle.
// Tune and lock words are registered out once the response slot is free, one per word.
// A dump streams one record per cycle from the pulse store's single read port
// while the response side accepts every word.
// Synchronous active-high reset restores register defaults; store contents stay undefined.
module band_sweep_lock_controller_unit #(
   parameter int unsigned MAX_PULSES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   bsl_req_if.sink                           req_if,
   bsl_rsp_if.source                         rsp_if,
   input  logic                              csr_we,
   input  logic [bsl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bsl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bsl_pkg::*;

   bsl_cmd_type  cmd;
   bsl_stat_type stat;
   logic         req_ready;

   assign req_if.ready = req_ready;

   bsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bsl_datapath #(
      .MAX_PULSES (MAX_PULSES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_if.operation),
      .req_now_us    (req_if.now_us),
      .req_now_ms    (req_if.now_ms),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_if        (rsp_if)
   );

endmodule

### tb/band_sweep_lock_controller_unit_tb.sv
// Self-checking testbench for the band sweep lock controller: predicts every response word.
`timescale 1ns / 1ps

module band_sweep_lock_controller_unit_tb;

   import bsl_pkg::*;

   localparam int unsigned MAX_PULSES     = 32;
   localparam int unsigned CLOCK_PERIOD   = 12;
   localparam int unsigned DRAIN_CYCLES   = MAX_PULSES + 16;
   localparam int unsigned HOLD_AFTER     = 120;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned PHASE_WORDS    = 30;
   localparam int unsigned TIMEOUT_CYCLES = 600000;

   typedef struct packed {
      bsl_kind_type kind;
      logic [7:0]   channel;
      logic [31:0]  width_us;
      logic         level;
      logic         is_short;
      logic [5:0]   total;
      logic         last;
   } report_type;

   class sweep_lock_tracker;
      logic [8:0]  chan_count;
      logic [15:0] dwell_ms;
      logic [5:0]  lock_min;
      logic [15:0] quiet_ms;
      logic [15:0] dump_gap_ms;
      logic [5:0]  dump_min;
      logic [15:0] short_us;
      bit          locked;
      bit          capture;
      logic [7:0]  sweep_ch;
      logic [7:0]  lock_ch;
      logic [31:0] entered_ms;
      logic [31:0] dumped_ms;
      logic [31:0] prev_edge_us;
      int unsigned fill;
      logic [31:0] widths [MAX_PULSES];
      report_type  reports [$];
      int unsigned mismatches;

      function new();
         chan_count   = CHANNEL_COUNT_RST;
         dwell_ms     = DWELL_MS_RST;
         lock_min     = LOCK_MIN_PULSES_RST;
         quiet_ms     = QUIET_MS_RST;
         dump_gap_ms  = DUMP_INTERVAL_MS_RST;
         dump_min     = DUMP_MIN_PULSES_RST;
         short_us     = SHORT_PULSE_US_RST;
         locked       = 1'b0;
         capture      = 1'b0;
         sweep_ch     = '0;
         lock_ch      = '0;
         entered_ms   = '0;
         dumped_ms    = '0;
         prev_edge_us = '0;
         fill         = 0;
         mismatches   = 0;
      endfunction

      function void set_reg(bsl_csr_type idx, logic [15:0] val);
         case (idx)
            CSR_CHANNEL_COUNT:    chan_count  = val[8:0];
            CSR_DWELL_MS:         dwell_ms    = val;
            CSR_LOCK_MIN_PULSES:  lock_min    = val[5:0];
            CSR_QUIET_MS:         quiet_ms    = val;
            CSR_DUMP_INTERVAL_MS: dump_gap_ms = val;
            CSR_DUMP_MIN_PULSES:  dump_min    = val[5:0];
            CSR_SHORT_PULSE_US:   short_us    = val;
            default: ;
         endcase
      endfunction

      function report_type make_report(bsl_kind_type k, logic [7:0] ch, logic [31:0] w,
                                       logic lvl, logic sh, logic [5:0] tot);
         report_type r;
         r.kind     = k;
         r.channel  = ch;
         r.width_us = w;
         r.level    = lvl;
         r.is_short = sh;
         r.total    = tot;
         r.last     = 1'b0;
         return r;
      endfunction

      function int unsigned next_ch(logic [7:0] c);
         int unsigned n;
         n = c + 1;
         if (n >= chan_count || n > 255) n = 0;
         return n;
      endfunction

      function void tune(int unsigned ch, logic [31:0] us, logic [31:0] ms);
         sweep_ch     = ch[7:0];
         fill         = 0;
         prev_edge_us = us;
         entered_ms   = ms;
         reports.push_back(make_report(KIND_TUNE, sweep_ch, '0, 1'b0, 1'b0, '0));
      endfunction

      function void note_event(bsl_op_type op, logic [31:0] us, logic [31:0] ms);
         int unsigned base;
         int unsigned total;
         int unsigned i;
         logic [31:0] gap;
         logic [31:0] idle;
         base = reports.size();
         case (op)
            OP_EDGE: begin
               gap = us - prev_edge_us;
               prev_edge_us = us;
               if (capture && fill < MAX_PULSES) begin
                  widths[fill] = gap;
                  fill++;
               end
            end
            OP_START: begin
               capture = 1'b1;
               locked  = 1'b0;
               tune(0, us, ms);
            end
            OP_STOP: capture = 1'b0;
            default: begin
               if (!locked) begin
                  if (fill >= lock_min) begin
                     locked    = 1'b1;
                     lock_ch   = sweep_ch;
                     dumped_ms = '0;
                     reports.push_back(make_report(KIND_LOCK, lock_ch, '0, 1'b0, 1'b0, '0));
                  end else if (ms - entered_ms >= dwell_ms) begin
                     tune(next_ch(sweep_ch), us, ms);
                  end
               end else begin
                  idle = us - prev_edge_us;
                  if (ms - dumped_ms >= dump_gap_ms && fill >= dump_min) begin
                     total     = fill;
                     dumped_ms = ms;
                     for (i = 0; i < total && i < MAX_PULSES; i++) begin
                        reports.push_back(make_report(KIND_RECORD, lock_ch, widths[i], i[0],
                                                      widths[i] < short_us, total[5:0]));
                     end
                     fill = 0;
                  end
                  if (64'(idle) > 64'(quiet_ms) * 64'd1000) begin
                     locked = 1'b0;
                     tune(next_ch(lock_ch), us, ms);
                  end
               end
            end
         endcase
         if (reports.size() > base) reports[$].last = 1'b1;
      endfunction

      function string show(report_type r);
         return $sformatf("kind %0d ch %0d width %h level %b short %b total %0d last %b",
                          r.kind, r.channel, r.width_us, r.level, r.is_short, r.total, r.last);
      endfunction

      function void check_report(report_type got);
         report_type want;
         if (reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word: %s", show(got));
            return;
         end
         want = reports.pop_front();
         if (got.kind !== want.kind || got.channel !== want.channel ||
             got.width_us !== want.width_us || got.level !== want.level ||
             got.is_short !== want.is_short || got.total !== want.total ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response mismatch: expected %s", show(want));
               $display("                   actual   %s", show(got));
            end
         end
      endfunction

      function int unsigned pending();
         return reports.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bsl_req_if req_if ();
   bsl_rsp_if rsp_if ();

   sweep_lock_tracker tracker;

   logic [31:0] cur_us;
   logic [31:0] cur_ms;
   int unsigned burst_left  = 0;
   int unsigned sent_words  = 0;
   int unsigned words_in    = 0;
   int unsigned words_out   = 0;
   int unsigned rsp_mode    = 0;
   int unsigned mode_left   = 0;
   logic        rsp_hold_on = 1'b0;

   band_sweep_lock_controller_unit #(.MAX_PULSES(MAX_PULSES)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin : watch
      report_type seen;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            tracker.note_event(bsl_op_type'(req_if.operation), req_if.now_us, req_if.now_ms);
            words_in++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            seen.kind     = bsl_kind_type'(rsp_if.kind);
            seen.channel  = rsp_if.channel;
            seen.width_us = rsp_if.pulse_width_us;
            seen.level    = rsp_if.pulse_level;
            seen.is_short = rsp_if.pulse_short;
            seen.total    = rsp_if.pulse_total;
            seen.last     = rsp_if.last;
            tracker.check_report(seen);
            words_out++;
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_hold_on) begin
         rsp_if.ready <= 1'b0;
      end else begin
         case (rsp_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 1) == 0);
            2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_if.ready <= ~rsp_if.ready;
         endcase
      end
      if (mode_left == 0) begin
         rsp_mode  <= $urandom_range(0, 3);
         mode_left <= $urandom_range(16, 160);
      end else begin
         mode_left <= mode_left - 1;
      end
   end

   // hold off the response side so the block backs up into its input
   initial begin
      wait (words_in >= HOLD_AFTER);
      @(posedge clock);
      rsp_hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold_on <= 1'b0;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("timeout with %0d response words still due", tracker.pending());
      $display("status: fail");
      $finish;
   end

   task automatic send_word(bsl_op_type op, logic [31:0] us, logic [31:0] ms);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.now_us    <= us;
      req_if.now_ms    <= ms;
      do @(posedge clock); while (!req_if.ready);
      sent_words++;
   endtask

   task automatic send_event(bsl_op_type op, int unsigned us_step, int unsigned ms_step);
      cur_us += us_step;
      cur_ms += ms_step;
      send_word(op, cur_us, cur_ms);
   endtask

   task automatic send_at(bsl_op_type op, logic [31:0] us, logic [31:0] ms);
      cur_us = us;
      cur_ms = ms;
      send_word(op, cur_us, cur_ms);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(bsl_csr_type idx, int unsigned val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      tracker.set_reg(idx, val[15:0]);
      @(posedge clock);
   endtask

   task automatic load_settings(int unsigned chans, int unsigned dwell, int unsigned lock_n,
                                int unsigned quiet, int unsigned dump_gap, int unsigned dump_n,
                                int unsigned short_lim);
      write_reg(CSR_CHANNEL_COUNT, chans);
      write_reg(CSR_DWELL_MS, dwell);
      write_reg(CSR_LOCK_MIN_PULSES, lock_n);
      write_reg(CSR_QUIET_MS, quiet);
      write_reg(CSR_DUMP_INTERVAL_MS, dump_gap);
      write_reg(CSR_DUMP_MIN_PULSES, dump_n);
      write_reg(CSR_SHORT_PULSE_US, short_lim);
      csr_we <= 1'b0;
   endtask

   task automatic random_settings();
      load_settings(($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 8),
                    $urandom_range(1, 200), $urandom_range(1, 12), $urandom_range(1, 20),
                    $urandom_range(1, 300), $urandom_range(1, 8), $urandom_range(1, 3000));
   endtask

   function automatic int unsigned edge_gap();
      int unsigned s;
      s = tracker.short_us;
      case ($urandom_range(0, 7))
         0: return $urandom();
         1: return $urandom_range(0, 3);
         2, 3, 4: return $urandom_range(1, s);
         default: return $urandom_range(s, 3 * s);
      endcase
   endfunction

   function automatic int unsigned poll_us_gap();
      int unsigned q;
      q = 1000 * tracker.quiet_ms;
      case ($urandom_range(0, 5))
         0, 1: return $urandom_range(0, 200);
         2: return q;
         3: return q + 1;
         default: return $urandom_range(0, 2 * q);
      endcase
   endfunction

   function automatic int unsigned poll_ms_gap();
      int unsigned d;
      d = tracker.dwell_ms;
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 3);
         1: return $urandom_range(d - 1, d + 1);
         2: return $urandom_range(0, 2 * tracker.dump_gap_ms);
         default: return $urandom_range(0, 2 * d);
      endcase
   endfunction

   task automatic run_session();
      int unsigned rounds;
      int unsigned n_edges;
      send_event(OP_START, $urandom_range(0, 5000), $urandom_range(0, 50));
      rounds = $urandom_range(1, 4);
      repeat (rounds) begin
         n_edges = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 40)
                                               : $urandom_range(0, tracker.lock_min + 3);
         repeat (n_edges) send_event(OP_EDGE, edge_gap(), $urandom_range(0, 2));
         if ($urandom_range(0, 7) == 0) send_event(OP_STOP, $urandom_range(0, 100), 0);
         repeat ($urandom_range(1, 3)) send_event(OP_POLL, poll_us_gap(), poll_ms_gap());
      end
   endtask

   task automatic run_noise();
      repeat ($urandom_range(1, 4)) begin
         send_at(bsl_op_type'($urandom_range(0, 3)), $urandom(), $urandom());
      end
   endtask

   task automatic run_phase(int unsigned quota);
      int unsigned goal;
      goal = sent_words + quota;
      while (sent_words < goal) begin
         if ($urandom_range(0, 3) != 0) run_session();
         else run_noise();
      end
      settle();
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_CHANNEL_COUNT;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.operation = OP_EDGE;
      req_if.now_us    = '0;
      req_if.now_ms    = '0;
      rsp_if.ready     = 1'b0;
      cur_us           = '0;
      cur_ms           = '0;
      tracker          = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: idle edge, quiet poll, then a dwell hop at the top of time
      send_at(OP_EDGE, 32'h0000_0000, 32'h0000_0000);
      send_at(OP_POLL, 32'hFFFF_FFFF, 32'h0000_0000);
      send_at(OP_POLL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      settle();

      load_settings(3, 5, 3, 2, 1, 2, 400);
      send_at(OP_START, 32'hFFFF_FF00, 32'hFFFF_FFF0);
      send_event(OP_EDGE, 100, 0);
      send_event(OP_EDGE, 900, 0);
      send_event(OP_EDGE, 400, 0);
      // lock wins over an expired dwell
      send_event(OP_POLL, 10, 20);
      send_event(OP_EDGE, 399, 0);
      send_event(OP_POLL, 10, 1);
      send_event(OP_POLL, 10, 5);
      send_event(OP_EDGE, 1, 0);
      send_event(OP_EDGE, 2, 0);
      // dump and resume on one poll
      send_event(OP_POLL, 2001, 1);
      send_event(OP_STOP, 0, 0);
      send_event(OP_EDGE, 5, 0);
      send_event(OP_POLL, 0, 5);
      send_event(OP_POLL, 0, 4);
      // hop past the last channel back to zero
      send_event(OP_POLL, 0, 1);
      settle();

      load_settings(256, 65535, 32, 65535, 65535, 32, 65535);
      run_phase(PHASE_WORDS);
      load_settings(1, 1, 1, 1, 1, 1, 1);
      run_phase(PHASE_WORDS);
      random_settings();
      run_phase(PHASE_WORDS);
      // zero channel count, lock and dump minimums
      load_settings(0, $urandom_range(1, 50), 0, $urandom_range(1, 10),
                    $urandom_range(1, 100), 0, $urandom_range(1, 2000));
      run_phase(PHASE_WORDS);
      random_settings();
      run_phase(PHASE_WORDS);

      $display("covered %0d event words and %0d response words over seven register settings,",
               words_in, words_out);
      $display("including saturated dumps, lock hold-offs and a long response stall");
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d response words never seen",
                  tracker.mismatches, tracker.pending());
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
design/bsl_pkg.sv
design/bsl_req_if.sv
design/bsl_rsp_if.sv
design/bsl_ctrl.sv
design/bsl_datapath.sv
design/band_sweep_lock_controller_unit.sv
tb/band_sweep_lock_controller_unit_tb.sv
